[rtl/thermal_printhead_strobe_sequencer_top_defines.svh]
// ----------------------------------------------------------------------------
// Thermal printhead strobe sequencer: assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMAL_PRINTHEAD_STROBE_SEQUENCER_TOP_DEFINES_SVH
`define THERMAL_PRINTHEAD_STROBE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define TPSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tpss_pkg.sv]
// ----------------------------------------------------------------------------
// Thermal printhead strobe sequencer package
// Commands, phase encodings, register indexes and derived sizes.
// ----------------------------------------------------------------------------
package tpss_pkg;

    localparam int LINE_BYTES  = 48;
    localparam int CHUNK_BYTES = 12;
    localparam int MAX_LINES   = 4096;

    localparam int CHUNKS_RAW  = (LINE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int CHUNKS_INT  = (CHUNKS_RAW > 4) ? 4 : ((CHUNKS_RAW < 1) ? 1 : CHUNKS_RAW);
    localparam int LINE_CAP_INT = (MAX_LINES > 4096) ? 4096 : MAX_LINES;

    localparam logic [2:0]  CHUNKS   = 3'(CHUNKS_INT);
    localparam logic [12:0] LINE_CAP = 13'(LINE_CAP_INT);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam logic [2:0] CFG_LATCH_US    = 3'd0;
    localparam logic [2:0] CFG_HEATER_US   = 3'd1;
    localparam logic [2:0] CFG_GAP_US      = 3'd2;
    localparam logic [2:0] CFG_FEED_INTV   = 3'd3;
    localparam logic [2:0] CFG_FEED_COUNT  = 3'd4;

    localparam logic [2:0] PHASE_IDLE  = 3'd0;
    localparam logic [2:0] PHASE_SEND  = 3'd1;
    localparam logic [2:0] PHASE_LATCH = 3'd2;
    localparam logic [2:0] PHASE_HEAT  = 3'd3;
    localparam logic [2:0] PHASE_GAP   = 3'd4;
    localparam logic [2:0] PHASE_FEED  = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SEND  = 6'b000010,
        PH_LATCH = 6'b000100,
        PH_HEAT  = 6'b001000,
        PH_GAP   = 6'b010000,
        PH_FEED  = 6'b100000
    } phase_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_SEND:  code = PHASE_SEND;
            PH_LATCH: code = PHASE_LATCH;
            PH_HEAT:  code = PHASE_HEAT;
            PH_GAP:   code = PHASE_GAP;
            PH_FEED:  code = PHASE_FEED;
            default:  code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

[rtl/thermal_printhead_strobe_sequencer_top.sv]
// Path: an accepted input beat goes through the input, then the result register.
// Throughput: one beat per cycle while out_stall is low; the sequencer state
//   register updates once per item as it moves from input to result register.
// Reset: asynchronous rst_n clears the job state and both pipeline valids and
//   loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
// Thermal printhead strobe sequencer
// Sequences chunk send, latch, heat, gap and extra feed phases per tick or event beat.
// ----------------------------------------------------------------------------
`include "thermal_printhead_strobe_sequencer_top_defines.svh"

module thermal_printhead_strobe_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [12:0] line_count,
    input  logic        paper_absent,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        latch_low,
    output logic        heater_on,
    output logic        send_valid,
    output logic [11:0] send_line,
    output logic [1:0]  send_chunk,
    output logic        motor_stop,
    output logic        start_rejected,
    output logic [2:0]  phase,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] latch_us_reg;
    logic [15:0] heater_us_reg;
    logic [15:0] gap_us_reg;
    logic [15:0] feed_intv_reg;
    logic [15:0] feed_count_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [12:0] s1_count_reg;
    logic        s1_paper_absent_reg;

    tpss_pkg::phase_t phase_reg, phase_next;
    logic [15:0] time_left_reg, time_left_next;
    logic [11:0] line_index_reg, line_index_next;
    logic [1:0]  chunk_index_reg, chunk_index_next;
    logic [12:0] total_lines_reg, total_lines_next;
    logic [15:0] feed_left_reg, feed_left_next;

    logic        out_valid_reg;
    logic        latch_low_reg;
    logic        heater_on_reg;
    logic        send_valid_reg;
    logic [11:0] send_line_reg;
    logic [1:0]  send_chunk_reg;
    logic        motor_stop_reg;
    logic        start_rejected_reg;
    logic [2:0]  phase_out_reg;

    logic        advance;
    logic        fire;
    logic        send;
    logic        stop_pulse;
    logic        rejected;
    logic [12:0] count_clamped;
    logic [15:0] feed_dec;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_us_reg   <= 16'd2;
            heater_us_reg  <= 16'd6500;
            gap_us_reg     <= 16'd150;
            feed_intv_reg  <= 16'd2000;
            feed_count_reg <= 16'd1200;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tpss_pkg::CFG_LATCH_US:   latch_us_reg   <= cfg_data;
                tpss_pkg::CFG_HEATER_US:  heater_us_reg  <= cfg_data;
                tpss_pkg::CFG_GAP_US:     gap_us_reg     <= cfg_data;
                tpss_pkg::CFG_FEED_INTV:  feed_intv_reg  <= cfg_data;
                tpss_pkg::CFG_FEED_COUNT: feed_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_cmd_reg          <= cmd;
            s1_count_reg        <= line_count;
            s1_paper_absent_reg <= paper_absent;
        end
    end

    assign count_clamped = (s1_count_reg > tpss_pkg::LINE_CAP) ? tpss_pkg::LINE_CAP
                                                               : s1_count_reg;
    assign feed_dec = feed_left_reg - 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        time_left_next   = time_left_reg;
        line_index_next  = line_index_reg;
        chunk_index_next = chunk_index_reg;
        total_lines_next = total_lines_reg;
        feed_left_next   = feed_left_reg;
        send             = 1'b0;
        stop_pulse       = 1'b0;
        rejected         = 1'b0;

        case (s1_cmd_reg)
            tpss_pkg::CMD_START:
            begin
                if (s1_paper_absent_reg || (s1_count_reg == 13'd0))
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    phase_next       = tpss_pkg::PH_SEND;
                    time_left_next   = 16'd0;
                    line_index_next  = 12'd0;
                    chunk_index_next = 2'd0;
                    total_lines_next = count_clamped;
                    feed_left_next   = 16'd0;
                    send             = 1'b1;
                end
            end
            tpss_pkg::CMD_DONE:
            begin
                if (phase_reg == tpss_pkg::PH_SEND)
                begin
                    phase_next     = tpss_pkg::PH_LATCH;
                    time_left_next = latch_us_reg;
                end
            end
            tpss_pkg::CMD_STOP:
            begin
                phase_next       = tpss_pkg::PH_IDLE;
                time_left_next   = 16'd0;
                line_index_next  = 12'd0;
                chunk_index_next = 2'd0;
                total_lines_next = 13'd0;
                feed_left_next   = 16'd0;
            end
            default:
            begin
                if (phase_reg inside {tpss_pkg::PH_LATCH, tpss_pkg::PH_HEAT,
                                      tpss_pkg::PH_GAP, tpss_pkg::PH_FEED})
                begin
                    if (time_left_reg > 16'd1)
                    begin
                        time_left_next = time_left_reg - 16'd1;
                    end
                    else if (phase_reg == tpss_pkg::PH_FEED)
                    begin
                        if (feed_dec != 16'd0)
                        begin
                            feed_left_next = feed_dec;
                            time_left_next = feed_intv_reg;
                        end
                        else
                        begin
                            stop_pulse       = 1'b1;
                            phase_next       = tpss_pkg::PH_IDLE;
                            time_left_next   = 16'd0;
                            line_index_next  = 12'd0;
                            chunk_index_next = 2'd0;
                            total_lines_next = 13'd0;
                            feed_left_next   = 16'd0;
                        end
                    end
                    else if (s1_paper_absent_reg)
                    begin
                        phase_next     = tpss_pkg::PH_FEED;
                        feed_left_next = feed_count_reg;
                        time_left_next = feed_intv_reg;
                    end
                    else if (phase_reg == tpss_pkg::PH_LATCH)
                    begin
                        phase_next     = tpss_pkg::PH_HEAT;
                        time_left_next = heater_us_reg;
                    end
                    else if (phase_reg == tpss_pkg::PH_HEAT)
                    begin
                        phase_next     = tpss_pkg::PH_GAP;
                        time_left_next = gap_us_reg;
                    end
                    else if (({1'b0, chunk_index_reg} + 3'd1) < tpss_pkg::CHUNKS)
                    begin
                        chunk_index_next = chunk_index_reg + 2'd1;
                        phase_next       = tpss_pkg::PH_SEND;
                        send             = 1'b1;
                    end
                    else if (({1'b0, line_index_reg} + 13'd1) < total_lines_reg)
                    begin
                        line_index_next  = line_index_reg + 12'd1;
                        chunk_index_next = 2'd0;
                        phase_next       = tpss_pkg::PH_SEND;
                        send             = 1'b1;
                    end
                    else
                    begin
                        phase_next     = tpss_pkg::PH_FEED;
                        feed_left_next = feed_count_reg;
                        time_left_next = feed_intv_reg;
                    end
                end
            end
        endcase
    end

    // advance sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tpss_pkg::PH_IDLE;
            time_left_reg   <= 16'd0;
            line_index_reg  <= 12'd0;
            chunk_index_reg <= 2'd0;
            total_lines_reg <= 13'd0;
            feed_left_reg   <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            time_left_reg   <= time_left_next;
            line_index_reg  <= line_index_next;
            chunk_index_reg <= chunk_index_next;
            total_lines_reg <= total_lines_next;
            feed_left_reg   <= feed_left_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            latch_low_reg      <= (phase_next == tpss_pkg::PH_LATCH);
            heater_on_reg      <= (phase_next == tpss_pkg::PH_LATCH) ||
                                  (phase_next == tpss_pkg::PH_HEAT);
            send_valid_reg     <= send;
            send_line_reg      <= send ? line_index_next : 12'd0;
            send_chunk_reg     <= send ? chunk_index_next : 2'd0;
            motor_stop_reg     <= stop_pulse;
            start_rejected_reg <= rejected;
            phase_out_reg      <= tpss_pkg::phase_code(phase_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign latch_low      = latch_low_reg;
    assign heater_on      = heater_on_reg;
    assign send_valid     = send_valid_reg;
    assign send_line      = send_line_reg;
    assign send_chunk     = send_chunk_reg;
    assign motor_stop     = motor_stop_reg;
    assign start_rejected = start_rejected_reg;
    assign phase          = phase_out_reg;

    `TPSS_ASSERT_NOW(a_latch_heats, out_valid && latch_low, heater_on,
        "latch low without heater on")
    `TPSS_ASSERT_NOW(a_send_phase, out_valid && send_valid, phase == tpss_pkg::PHASE_SEND,
        "chunk request outside sending phase")
    `TPSS_ASSERT_NOW(a_stop_idle, out_valid && motor_stop, phase == tpss_pkg::PHASE_IDLE,
        "motor stop pulse without return to idle")
    `TPSS_ASSERT_NOW(a_reject_quiet, out_valid && start_rejected, !send_valid && !motor_stop,
        "rejected start produced a request or stop")
    `TPSS_ASSERT_NEXT(a_stall_holds, in_stall, s1_valid_reg,
        "input register lost a stalled beat")

endmodule

[dv/thermal_printhead_strobe_sequencer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal printhead strobe sequencer testbench
// Feeds tick and event beats through random idling, long receiver hold-offs
// and several timing register settings. A behavioural copy of the sequencer
// predicts every result beat, and each field is checked in order of arrival.
// ----------------------------------------------------------------------------
module thermal_printhead_strobe_sequencer_top_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_OFF_LEN = 400;
    localparam int PHASE_BEATS  = 120;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [12:0] line_count;
        logic        paper_absent;
    } job_beat_t;

    typedef struct packed {
        logic        latch_low;
        logic        heater_on;
        logic        send_valid;
        logic [11:0] send_line;
        logic [1:0]  send_chunk;
        logic        motor_stop;
        logic        start_rejected;
        logic [2:0]  phase;
    } strobe_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = tpss_pkg::CMD_TICK;
    logic [12:0] line_count = 13'd0;
    logic        paper_absent = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        latch_low;
    logic        heater_on;
    logic        send_valid;
    logic [11:0] send_line;
    logic [1:0]  send_chunk;
    logic        motor_stop;
    logic        start_rejected;
    logic [2:0]  phase;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = tpss_pkg::CFG_LATCH_US;
    logic [15:0] cfg_data = 16'd0;

    // timing registers as the block should hold them
    logic [15:0] reg_latch;
    logic [15:0] reg_heater;
    logic [15:0] reg_gap;
    logic [15:0] reg_feed_intv;
    logic [15:0] reg_feed_count;

    // sequencer state as the block should hold it
    logic [2:0]  seq_phase;
    logic [15:0] seq_time;
    logic [11:0] seq_line;
    logic [1:0]  seq_chunk;
    logic [12:0] seq_total;
    logic [15:0] seq_feed;

    job_beat_t   pending_beats[$];
    strobe_out_t predicted_outputs[$];
    strobe_out_t seen;
    strobe_out_t want;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_req = 0;
    int hold_off_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int n_beats = 0;
    int n_results = 0;
    int n_settings = 0;
    int n_requests = 0;
    int n_motor_stops = 0;
    int n_refused = 0;

    thermal_printhead_strobe_sequencer_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .line_count     (line_count),
        .paper_absent   (paper_absent),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .latch_low      (latch_low),
        .heater_on      (heater_on),
        .send_valid     (send_valid),
        .send_line      (send_line),
        .send_chunk     (send_chunk),
        .motor_stop     (motor_stop),
        .start_rejected (start_rejected),
        .phase          (phase),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic void clear_job();
        seq_phase = tpss_pkg::PHASE_IDLE;
        seq_time  = 16'd0;
        seq_line  = 12'd0;
        seq_chunk = 2'd0;
        seq_total = 13'd0;
        seq_feed  = 16'd0;
    endfunction

    function automatic void start_feed();
        seq_phase = tpss_pkg::PHASE_FEED;
        seq_feed  = reg_feed_count;
        seq_time  = reg_feed_intv;
    endfunction

    function automatic strobe_out_t step_sequencer(input job_beat_t b);
        strobe_out_t r;
        logic [12:0] lines;
        logic        issue;
        logic        stop_pulse;
        logic        refused;
        issue      = 1'b0;
        stop_pulse = 1'b0;
        refused    = 1'b0;
        lines      = b.line_count;
        case (b.cmd)
            tpss_pkg::CMD_START:
            begin
                if (b.paper_absent || lines == 13'd0)
                    refused = 1'b1;
                else
                begin
                    if (lines > tpss_pkg::LINE_CAP)
                        lines = tpss_pkg::LINE_CAP;
                    clear_job();
                    seq_total = lines;
                    seq_phase = tpss_pkg::PHASE_SEND;
                    issue     = 1'b1;
                end
            end
            tpss_pkg::CMD_DONE:
            begin
                if (seq_phase == tpss_pkg::PHASE_SEND)
                begin
                    seq_phase = tpss_pkg::PHASE_LATCH;
                    seq_time  = reg_latch;
                end
            end
            tpss_pkg::CMD_STOP:
                clear_job();
            default:
            begin
                if (seq_phase >= tpss_pkg::PHASE_LATCH && seq_phase <= tpss_pkg::PHASE_FEED)
                begin
                    if (seq_time > 16'd1)
                        seq_time = seq_time - 16'd1;
                    else if (seq_phase == tpss_pkg::PHASE_FEED)
                    begin
                        seq_feed = seq_feed - 16'd1;
                        if (seq_feed != 16'd0)
                            seq_time = reg_feed_intv;
                        else
                        begin
                            stop_pulse = 1'b1;
                            clear_job();
                        end
                    end
                    else if (b.paper_absent)
                        start_feed();
                    else if (seq_phase == tpss_pkg::PHASE_LATCH)
                    begin
                        seq_phase = tpss_pkg::PHASE_HEAT;
                        seq_time  = reg_heater;
                    end
                    else if (seq_phase == tpss_pkg::PHASE_HEAT)
                    begin
                        seq_phase = tpss_pkg::PHASE_GAP;
                        seq_time  = reg_gap;
                    end
                    else if (seq_chunk + 1 < tpss_pkg::CHUNKS_INT)
                    begin
                        seq_chunk = seq_chunk + 2'd1;
                        seq_phase = tpss_pkg::PHASE_SEND;
                        issue     = 1'b1;
                    end
                    else if (seq_line + 1 < seq_total)
                    begin
                        seq_line  = seq_line + 12'd1;
                        seq_chunk = 2'd0;
                        seq_phase = tpss_pkg::PHASE_SEND;
                        issue     = 1'b1;
                    end
                    else
                        start_feed();
                end
            end
        endcase
        r.latch_low      = (seq_phase == tpss_pkg::PHASE_LATCH);
        r.heater_on      = (seq_phase == tpss_pkg::PHASE_LATCH) ||
                           (seq_phase == tpss_pkg::PHASE_HEAT);
        r.send_valid     = issue;
        r.send_line      = issue ? seq_line : 12'd0;
        r.send_chunk     = issue ? seq_chunk : 2'd0;
        r.motor_stop     = stop_pulse;
        r.start_rejected = refused;
        r.phase          = seq_phase;
        return r;
    endfunction

    task automatic queue_beat(input logic [1:0] c, input logic [12:0] n, input logic np);
        pending_beats.push_back('{c, n, np});
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || predicted_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tpss_pkg::CFG_LATCH_US:   reg_latch = val;
            tpss_pkg::CFG_HEATER_US:  reg_heater = val;
            tpss_pkg::CFG_GAP_US:     reg_gap = val;
            tpss_pkg::CFG_FEED_INTV:  reg_feed_intv = val;
            tpss_pkg::CFG_FEED_COUNT: reg_feed_count = val;
            default:                  ;
        endcase
    endtask

    task automatic program_timing(input logic [15:0] l, input logic [15:0] h,
                                  input logic [15:0] g, input logic [15:0] fi,
                                  input logic [15:0] fc);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(tpss_pkg::CFG_LATCH_US, l);
        write_reg(tpss_pkg::CFG_HEATER_US, h);
        write_reg(tpss_pkg::CFG_GAP_US, g);
        write_reg(tpss_pkg::CFG_FEED_INTV, fi);
        write_reg(tpss_pkg::CFG_FEED_COUNT, fc);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic queue_print_job(inout int counted);
        int lines;
        lines = $urandom_range(1, 3);
        queue_beat(tpss_pkg::CMD_START, 13'(lines), 1'b0);
        counted++;
        for (int k = 0; k < lines * tpss_pkg::CHUNKS_INT; k++)
        begin
            repeat ($urandom_range(0, 2))
                queue_beat(tpss_pkg::CMD_TICK, 13'($urandom), 1'($urandom));
            if ($urandom_range(0, 99) < 3)
            begin
                queue_beat(tpss_pkg::CMD_STOP, 13'($urandom), 1'($urandom));
                counted++;
                return;
            end
            if ($urandom_range(0, 99) < 3)
            begin
                queue_beat(tpss_pkg::CMD_START, 13'($urandom_range(1, 3)), 1'b0);
                counted++;
            end
            queue_beat(tpss_pkg::CMD_DONE, 13'($urandom), 1'($urandom));
            counted++;
            repeat (int'(reg_latch) + int'(reg_heater) + int'(reg_gap))
            begin
                queue_beat(tpss_pkg::CMD_TICK, 13'($urandom), $urandom_range(0, 99) < 2);
                counted++;
            end
        end
        repeat (int'(reg_feed_count) * int'(reg_feed_intv) + 1)
        begin
            queue_beat(tpss_pkg::CMD_TICK, 13'($urandom), 1'($urandom));
            counted++;
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int stall_p, input bit hold);
        int counted;
        int c;
        program_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                       16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                       16'($urandom_range(1, 3)));
        send_idle_pct = send_pct;
        stall_pct     = stall_p;
        for (int half = 0; half < 2; half++)
        begin
            counted = 0;
            while (counted < PHASE_BEATS / 2)
            begin
                if ($urandom_range(0, 99) < 80)
                    queue_print_job(counted);
                else
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        c = $urandom_range(0, 3);
                        queue_beat(2'(c), 13'($urandom_range(0, 8191)), 1'($urandom));
                        if (c != tpss_pkg::CMD_TICK)
                            counted++;
                    end
                end
            end
            if (hold && half == 0)
                hold_off_req++;
            // hold the sender until every result is back
            wait_drained();
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted_outputs.push_back(step_sequencer(pending_beats.pop_front()));
                n_beats++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid     <= 1'b1;
                    cmd          <= pending_beats[0].cmd;
                    line_count   <= pending_beats[0].line_count;
                    paper_absent <= pending_beats[0].paper_absent;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{latch_low, heater_on, send_valid, send_line, send_chunk,
                         motor_stop, start_rejected, phase};
                n_results++;
                if (predicted_outputs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat %0d arrived with none expected",
                                 $time, n_results);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: result beat %0d mismatch", $time, n_results);
                            $display("  exp l=%b h=%b s=%b ln=%0d ck=%0d st=%b rj=%b ph=%0d",
                                     want.latch_low, want.heater_on, want.send_valid,
                                     want.send_line, want.send_chunk, want.motor_stop,
                                     want.start_rejected, want.phase);
                            $display("  act l=%b h=%b s=%b ln=%0d ck=%0d st=%b rj=%b ph=%0d",
                                     seen.latch_low, seen.heater_on, seen.send_valid,
                                     seen.send_line, seen.send_chunk, seen.motor_stop,
                                     seen.start_rejected, seen.phase);
                        end
                    end
                end
                n_requests    += seen.send_valid;
                n_motor_stops += seen.motor_stop;
                n_refused     += seen.start_rejected;
            end
            if (hold_off_served != hold_off_req)
            begin
                hold_off_served = hold_off_req;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        reg_latch      = 16'd2;
        reg_heater     = 16'd6500;
        reg_gap        = 16'd150;
        reg_feed_intv  = 16'd2000;
        reg_feed_count = 16'd1200;
        clear_job();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default timing: rejects, clamp, latch length, abort by stop
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_DONE, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_START, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_START, 13'd5, 1'b1);
        queue_beat(tpss_pkg::CMD_START, 13'd8191, 1'b0);
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_DONE, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_START, 13'd0, 1'b1);
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_STOP, 13'd0, 1'b0);

        // shortest timing: full line, line advance, restart, paper out, motor stop
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        queue_beat(tpss_pkg::CMD_START, 13'd2, 1'b0);
        repeat (tpss_pkg::CHUNKS_INT)
        begin
            queue_beat(tpss_pkg::CMD_DONE, 13'd0, 1'b0);
            repeat (3) queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        end
        queue_beat(tpss_pkg::CMD_START, 13'd4096, 1'b0);
        queue_beat(tpss_pkg::CMD_DONE, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b1);
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);

        // longest latch load, paper out before expiry
        program_timing(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'hFFFF);
        queue_beat(tpss_pkg::CMD_START, 13'd1, 1'b0);
        queue_beat(tpss_pkg::CMD_DONE, 13'd0, 1'b0);
        repeat (20) queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b1);
        queue_beat(tpss_pkg::CMD_STOP, 13'd0, 1'b0);

        // longest heat load; gap and feed interval also set to their maximum
        program_timing(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        queue_beat(tpss_pkg::CMD_START, 13'd1, 1'b0);
        queue_beat(tpss_pkg::CMD_DONE, 13'd0, 1'b0);
        repeat (21) queue_beat(tpss_pkg::CMD_TICK, 13'd0, 1'b0);
        queue_beat(tpss_pkg::CMD_STOP, 13'd0, 1'b0);

        run_random_phase(0, 0, 1'b1);
        run_random_phase(55, 0, 1'b0);
        run_random_phase(0, 55, 1'b0);
        run_random_phase(29, 29, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        fail_count += predicted_outputs.size();
        $display("Run moved %0d beats through %0d timing settings with idling and hold-offs,",
                 n_beats, n_settings + 1);
        $display("seeing %0d chunk requests, %0d motor stops and %0d refused starts.",
                 n_requests, n_motor_stops, n_refused);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
